@@ hw/rtl/wpnm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpnm_pkg
// shared types, constants and helpers for the wildcard pattern nth-match search
// ----------------------------------------------------------------------------
package wpnm_pkg;

	// sizes
	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
	localparam int LEN_W       = 5;
	localparam int MATCH_W     = 32;
	localparam int OCC_W       = 32;
	localparam int MOFS_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_BAD_LEN   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCCUR    = 3'd4;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0]        status;
		logic [MOFS_W-1:0] match_offset;
	} out_word_t;

	// configuration seen by the search core
	typedef struct packed {
		logic [63:0]      pattern_bytes_low;
		logic [63:0]      pattern_bytes_high;
		logic [LEN_W-1:0] pattern_length;
		logic [7:0]       wildcard_byte;
		logic [OCC_W-1:0] occurrence_index;
	} cfg_t;

	// pick pattern byte j out of the two pattern registers
	function automatic logic [7:0] pat_byte(input cfg_t cfg, input logic [PAT_IDX_W-1:0] j);
		logic [127:0] pat;
		pat = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};
		return pat[j*8 +: 8];
	endfunction

endpackage

@@ hw/rtl/wpnm_cfg.sv @@
// ----------------------------------------------------------------------------
// wpnm_cfg
// configuration register file written through the config channel
// ----------------------------------------------------------------------------
module wpnm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wpnm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wpnm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wpnm_pkg::cfg_t                   cfg
);

	wpnm_pkg::cfg_t cfg_q;

	// writes are taken in any cycle
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes_low  <= '0;
			cfg_q.pattern_bytes_high <= '0;
			cfg_q.pattern_length     <= wpnm_pkg::LEN_W'(1);
			cfg_q.wildcard_byte      <= '0;
			cfg_q.occurrence_index   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wpnm_pkg::REG_PAT_LOW:  cfg_q.pattern_bytes_low  <= cfg_data;
				wpnm_pkg::REG_PAT_HIGH: cfg_q.pattern_bytes_high <= cfg_data;
				wpnm_pkg::REG_PAT_LEN:  cfg_q.pattern_length     <= cfg_data[wpnm_pkg::LEN_W-1:0];
				wpnm_pkg::REG_WILDCARD: cfg_q.wildcard_byte      <= cfg_data[7:0];
				wpnm_pkg::REG_OCCUR:    cfg_q.occurrence_index   <= cfg_data[wpnm_pkg::OCC_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/wpnm_core.sv @@
// ----------------------------------------------------------------------------
// wpnm_core
// input register, byte window, parallel wildcard compare and match counters
// ----------------------------------------------------------------------------
module wpnm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wpnm_pkg::in_word_t  in_word,
	input  wpnm_pkg::cfg_t      cfg,
	input  logic                room,
	output logic                res_valid,
	output wpnm_pkg::out_word_t res_word
);

	localparam logic [wpnm_pkg::OFFSET_BITS-1:0] SEEN_MAX = '1;
	localparam logic [wpnm_pkg::MATCH_W-1:0]     MATCH_MAX = '1;
	localparam int LANE_W = wpnm_pkg::LEN_W + 1;

	logic                           valid_s1;
	wpnm_pkg::in_word_t             word_s1;
	logic                           advance;

	logic [7:0]                     window_q [wpnm_pkg::MAX_PATTERN];
	logic [7:0]                     win_nxt  [wpnm_pkg::MAX_PATTERN];
	logic [wpnm_pkg::OFFSET_BITS-1:0] seen_q;
	logic [wpnm_pkg::OFFSET_BITS-1:0] seen_nxt;
	logic [wpnm_pkg::MATCH_W-1:0]   matches_q;
	logic                           done_q;

	logic                           bad_len;
	logic [wpnm_pkg::MAX_PATTERN-1:0] lane_ok;
	logic                           win_hit;
	logic                           hit_is_nth;
	logic                           found;
	logic [wpnm_pkg::OFFSET_BITS-1:0] start_ofs;

	// input register advances when the result side has room
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// length check
	assign bad_len = (cfg.pattern_length == '0) ||
		(cfg.pattern_length > wpnm_pkg::LEN_W'(wpnm_pkg::MAX_PATTERN));

	// window after taking the new byte, newest at the top
	always_comb begin
		for (int i = 0; i < wpnm_pkg::MAX_PATTERN - 1; i++) begin
			win_nxt[i] = window_q[i+1];
		end
		win_nxt[wpnm_pkg::MAX_PATTERN-1] = word_s1.data_byte;
	end

	// saturating byte count
	assign seen_nxt = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;

	// per-lane compare: lane i holds pattern byte i + len - MAX_PATTERN
	always_comb begin
		logic [LANE_W-1:0]             sum;
		logic [wpnm_pkg::PAT_IDX_W-1:0] j;
		logic [7:0]                    p;
		for (int i = 0; i < wpnm_pkg::MAX_PATTERN; i++) begin
			sum = LANE_W'(cfg.pattern_length) + LANE_W'(i);
			j   = wpnm_pkg::PAT_IDX_W'(sum - LANE_W'(wpnm_pkg::MAX_PATTERN));
			p   = wpnm_pkg::pat_byte(cfg, j);
			lane_ok[i] = (sum < LANE_W'(wpnm_pkg::MAX_PATTERN)) ||
				(p == cfg.wildcard_byte) || (p == win_nxt[i]);
		end
	end

	assign win_hit    = (seen_nxt >= wpnm_pkg::OFFSET_BITS'(cfg.pattern_length)) && (&lane_ok);
	assign hit_is_nth = (wpnm_pkg::OCC_W'(matches_q) == cfg.occurrence_index);
	assign found      = win_hit && hit_is_nth;
	assign start_ofs  = seen_nxt - wpnm_pkg::OFFSET_BITS'(cfg.pattern_length);

	// result selection
	always_comb begin
		res_valid             = 1'b0;
		res_word.status       = wpnm_pkg::ST_NOT_FOUND;
		res_word.match_offset = '0;
		if (advance && !done_q) begin
			if (bad_len) begin
				res_valid       = 1'b1;
				res_word.status = wpnm_pkg::ST_BAD_LEN;
			end else if (found) begin
				res_valid             = 1'b1;
				res_word.status       = wpnm_pkg::ST_FOUND;
				res_word.match_offset = wpnm_pkg::MOFS_W'(start_ofs);
			end else if (word_s1.last_byte) begin
				res_valid       = 1'b1;
				res_word.status = wpnm_pkg::ST_NOT_FOUND;
			end
		end
	end

	// region state; last byte rearms everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wpnm_pkg::MAX_PATTERN; i++) begin
				window_q[i] <= '0;
			end
			seen_q    <= '0;
			matches_q <= '0;
			done_q    <= 1'b0;
		end else if (advance) begin
			if (word_s1.last_byte) begin
				for (int i = 0; i < wpnm_pkg::MAX_PATTERN; i++) begin
					window_q[i] <= '0;
				end
				seen_q    <= '0;
				matches_q <= '0;
				done_q    <= 1'b0;
			end else if (!done_q) begin
				if (bad_len) begin
					done_q <= 1'b1;
				end else begin
					window_q <= win_nxt;
					seen_q   <= seen_nxt;
					if (found) begin
						done_q <= 1'b1;
					end else if (win_hit && matches_q != MATCH_MAX) begin
						matches_q <= matches_q + 1'b1;
					end
				end
			end
		end
	end

	// a last byte leaves the counters clear
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last_byte |=> seen_q == '0 && matches_q == '0 && !done_q)
		else $error("counters not cleared after last byte");

	// once done, only a last byte clears the done flag
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !(advance && word_s1.last_byte) |=> done_q)
		else $error("done flag dropped mid region");

	// no result while the region is done
	a_no_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !res_valid)
		else $error("result given after region finished");

endmodule

@@ hw/rtl/wpnm_skid.sv @@
// ----------------------------------------------------------------------------
// wpnm_skid
// result register with a skid stage so the core keeps running under stall until the skid fills
// ----------------------------------------------------------------------------
module wpnm_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  wpnm_pkg::out_word_t res_word,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output wpnm_pkg::out_word_t out_word
);

	logic                out_valid_q;
	wpnm_pkg::out_word_t out_q;
	logic                skid_valid_q;
	wpnm_pkg::out_word_t skid_q;
	logic                take;

	assign take      = out_valid_q && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || take) begin
				out_q <= res_word;
			end else begin
				skid_q <= res_word;
			end
		end
	end

	// skid only fills behind a held output word
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word with output empty");

	// a waiting output word stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("output word changed while waiting");

	// skid word stays until the output drains
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !take |=> skid_valid_q)
		else $error("skid word lost before output taken");

endmodule

@@ hw/rtl/wildcard_pattern_nth_match_top.sv @@
// result path: a byte is held in the core input register, its result in the output register
// throughput: one byte per cycle unless stalled; one parallel window compare over 16 lanes
// a held result stalls input only once the skid stage behind the output register is full
// reset: arst_n clears window, counters and valid flags; cfg registers return to defaults
// ----------------------------------------------------------------------------
// wildcard_pattern_nth_match_top
// streaming wildcard byte-pattern search reporting the nth match of a region
// ----------------------------------------------------------------------------
module wildcard_pattern_nth_match_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  wpnm_pkg::in_word_t               in_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output wpnm_pkg::out_word_t              out_word,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wpnm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wpnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	wpnm_pkg::cfg_t      cfg;
	logic                room;
	logic                res_valid;
	wpnm_pkg::out_word_t res_word;

	// configuration registers
	wpnm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// search core
	wpnm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.cfg       (cfg),
		.room      (room),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	// result buffering
	wpnm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_word  (res_word),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
